FILE: sv/dtpb_pkg.sv
// Shared types and constants for the drop-tail packet buffer.
package dtpb_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int TIME_WIDTH_DEF = 32;

    localparam int CFG_W   = 11;
    localparam int ARR_W   = 32;
    localparam int PROC_W  = 16;
    localparam int START_W = 32;

    localparam logic [CFG_W-1:0] BUF_SIZE_RST = CFG_W'(1);

    typedef struct packed {
        logic [ARR_W-1:0]  arrive_ts;
        logic [PROC_W-1:0] svc_len;
    } in_item_t;

    typedef struct packed {
        logic               dropped;
        logic [START_W-1:0] begin_ts;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the incoming request
        logic commit;  // decide, update the ring and load the result register
    } dp_cmd_t;

endpackage

FILE: sv/dtpb_ctrl.sv
// Controller: request sequencing and result register handshake.
module dtpb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output dtpb_pkg::dp_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic commit;

    assign s_ready    = (state_reg == ST_IDLE);
    assign commit     = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign cmd.load   = s_valid && s_ready;
    assign cmd.commit = commit;
    assign m_valid    = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (commit) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (commit) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: sv/dtpb_dp.sv
// Datapath: finish-time ring memory, pointers, drop decision and result register.
module dtpb_dp #(
    parameter int DEPTH      = dtpb_pkg::DEPTH_DEF,
    parameter int TIME_WIDTH = dtpb_pkg::TIME_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dtpb_pkg::dp_cmd_t           cmd,
    input  dtpb_pkg::in_item_t          s_data,
    output dtpb_pkg::out_item_t         m_data,
    input  logic                        cfg_we,
    input  logic [dtpb_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int W     = TIME_WIDTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > dtpb_pkg::CFG_W) ? CNT_W : dtpb_pkg::CFG_W;
    localparam int AW    = (W > dtpb_pkg::ARR_W) ? W : dtpb_pkg::ARR_W;

    logic [W-1:0] ring_mem [DEPTH];
    logic [W-1:0] ring_rd_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [W-1:0]     newest_reg, newest_next;
    logic [dtpb_pkg::CFG_W-1:0] buf_size_reg;

    logic [dtpb_pkg::ARR_W-1:0]  arr_reg;
    logic [dtpb_pkg::PROC_W-1:0] proc_reg;
    dtpb_pkg::out_item_t         out_reg;

    logic [AW-1:0]    arr_wide;
    logic [W-1:0]     arr_t;
    logic [CMP_W-1:0] bs_ext, cap;
    logic             cap_zero, empty, retire, has_room, push, drop;
    logic [W-1:0]     start_val;
    logic [W:0]       sum;
    logic [W-1:0]     finish;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // arrival clamped to the time range
    assign arr_wide = AW'(arr_reg);
    assign arr_t    = (arr_wide > AW'({W{1'b1}})) ? {W{1'b1}} : W'(arr_wide);

    assign bs_ext   = CMP_W'(buf_size_reg);
    assign cap      = (bs_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : bs_ext;
    assign cap_zero = (buf_size_reg == '0);
    assign empty    = (count_reg == '0);
    assign retire   = !empty && (arr_t >= ring_rd_reg);
    assign has_room = (CMP_W'(count_reg) < cap);
    assign push     = !cap_zero && (empty || retire || has_room);
    assign drop     = !push;

    always_comb begin
        if (empty) begin
            start_val = arr_t;
        end else if (retire) begin
            start_val = (arr_t > newest_reg) ? arr_t : newest_reg;
        end else begin
            start_val = newest_reg;
        end
    end

    // saturating finish time
    assign sum    = {1'b0, start_val} + (W+1)'(proc_reg);
    assign finish = sum[W] ? {W{1'b1}} : sum[W-1:0];

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        newest_next = newest_reg;
        if (cmd.commit && push) begin
            tail_next   = ptr_inc(tail_reg);
            newest_next = finish;
            if (retire) begin
                head_next = ptr_inc(head_reg);
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            newest_reg   <= '0;
            buf_size_reg <= dtpb_pkg::BUF_SIZE_RST;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            newest_reg <= newest_next;
            if (cfg_we) buf_size_reg <= cfg_wdata;
        end
    end

    // ring memory: one write, one registered read of the oldest entry
    always_ff @(posedge aclk) begin
        if (cmd.commit && push) ring_mem[tail_reg] <= finish;
        ring_rd_reg <= ring_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            arr_reg  <= s_data.arrive_ts;
            proc_reg <= s_data.svc_len;
        end
        if (cmd.commit) begin
            out_reg.dropped  <= drop;
            out_reg.begin_ts <= drop ? '0 : dtpb_pkg::START_W'(start_val);
        end
    end

    assign m_data = out_reg;

endmodule

FILE: sv/drop_tail_packet_buffer_sim.sv
// Top level of the drop-tail packet buffer: single-server queue with finite buffer.
//
//   channel   dir   handshake          payload
//   s_*       in    s_valid/s_ready    in_item_t  {arrive_ts, svc_len}
//   m_*       out   m_valid/m_ready    out_item_t {dropped, begin_ts}
//   cfg_*     in    cfg_we             cfg_wdata = buffer_size
//
// A request is first taken, with the oldest finish time read from the ring memory, and
// then decided: the ring is written and the result register loaded; no new request is
// taken before that. A result held by a low m_ready stalls the decision until it is taken.
// Synchronous reset empties the ring by clearing pointers, count and newest finish time; the memory is kept.
module drop_tail_packet_buffer_sim #(
    parameter int DEPTH      = dtpb_pkg::DEPTH_DEF,
    parameter int TIME_WIDTH = dtpb_pkg::TIME_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  dtpb_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output dtpb_pkg::out_item_t         m_data,
    input  logic                        cfg_we,
    input  logic [dtpb_pkg::CFG_W-1:0]  cfg_wdata
);

    dtpb_pkg::dp_cmd_t cmd;

    dtpb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dtpb_dp #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule

FILE: sv/dtpb_check.sv
// Port-level checks for the drop-tail packet buffer, bound to the top level.
module dtpb_check (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dtpb_pkg::out_item_t m_data
);

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one request in flight: never taken on consecutive cycles
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.dropped |-> m_data.begin_ts == '0)
        else $error("dropped request with nonzero start time");

    // a new result is produced only by the working phase
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a request in work");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind drop_tail_packet_buffer_sim dtpb_check u_dtpb_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
